>>> hdl/pixel_graph_edge_weights_unit_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the pixel graph edge weights unit
// ----------------------------------------------------------------------------
`ifndef PIXEL_GRAPH_EDGE_WEIGHTS_UNIT_MACROS_SVH
`define PIXEL_GRAPH_EDGE_WEIGHTS_UNIT_MACROS_SVH

// same-cycle implication
`define PGE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PGE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pge_pkg
// shared types and constants of the pixel graph edge weights unit
// ----------------------------------------------------------------------------
package pge_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_BANDS   = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_BITS  = 24;
    localparam int NUM_BANDS   = 4;
    localparam int DIST_BITS   = 22;
    localparam int TERM_LIMIT  = 28;

    localparam logic [31:0] TERM_MAX  = 32'h0FFF_FFFF;
    localparam logic [31:0] DIST_MAX  = 32'h003F_FFFF;
    localparam logic [31:0] ROUND_ADD = 32'd1024;

    // configuration register indexes
    localparam logic [2:0] REG_WEIGHT_A    = 3'd0;
    localparam logic [2:0] REG_WEIGHT_B    = 3'd1;
    localparam logic [2:0] REG_WEIGHT_C    = 3'd2;
    localparam logic [2:0] REG_WEIGHT_D    = 3'd3;
    localparam logic [2:0] REG_BANDS_USED  = 3'd4;
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_CALC,
        S_LOAD
    } pge_state_t;

    typedef struct packed {
        logic valid;
        logic used;
    } pge_lane_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pge_merge_st_t;

endpackage

>>> hdl/pixel_graph_edge_weights_unit.sv
`timescale 1ns / 1ps
// sequence: a pixel with no edge frees the input after S_READ; each edge goes
//   through S_START, the band lanes, the summing, the root steps (23 at 16-bit
//   samples) and the S_LOAD handoff to the output register
// one pixel at a time: no new transfer until the last edge of a pixel is loaded
// reset: rst_n asynchronous active low; weights 8192, four bands, width 4096,
//   row store contents undefined until written by the first row
// ----------------------------------------------------------------------------
// pixel_graph_edge_weights_unit
// emits left and upper graph edges with weighted euclidean distance
// ----------------------------------------------------------------------------
`include "pixel_graph_edge_weights_unit_macros.svh"

module pixel_graph_edge_weights_unit #(
    parameter int MAX_WIDTH   = pge_pkg::MAX_WIDTH,
    parameter int SAMPLE_BITS = pge_pkg::SAMPLE_BITS,
    parameter int INDEX_BITS  = pge_pkg::INDEX_BITS
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               cfg_wr_en,
    input  logic [2:0]                                         cfg_index,
    input  logic [15:0]                                        cfg_data,
    input  logic                                               s_tvalid,
    output logic                                               s_tready,
    // band_a, band_b, band_c, band_d
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]                 s_tdata,
    // pixel_kept, frame_start
    input  logic [1:0]                                         s_tuser,
    output logic                                               m_tvalid,
    input  logic                                               m_tready,
    // node_from, node_to, edge_distance
    output logic [((2*INDEX_BITS+pge_pkg::DIST_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                               m_tlast
);

    localparam int PIX_W     = pge_pkg::NUM_BANDS * SAMPLE_BITS;
    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW        = $clog2(MAX_WIDTH + 1);
    localparam int OUT_W     = ((2*INDEX_BITS+pge_pkg::DIST_BITS+7)/8)*8;
    localparam int TERM_BITS = (SAMPLE_BITS + 6 > pge_pkg::TERM_LIMIT)
                               ? pge_pkg::TERM_LIMIT : SAMPLE_BITS + 6;

    // configuration
    logic [3:0][15:0] weight_reg;
    logic [2:0]       bands_used_reg;
    logic [12:0]      image_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg      <= {4{16'd8192}};
            bands_used_reg  <= 3'd4;
            image_width_reg <= 13'd4096;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pge_pkg::REG_WEIGHT_A:    weight_reg[0]   <= cfg_data;
                pge_pkg::REG_WEIGHT_B:    weight_reg[1]   <= cfg_data;
                pge_pkg::REG_WEIGHT_C:    weight_reg[2]   <= cfg_data;
                pge_pkg::REG_WEIGHT_D:    weight_reg[3]   <= cfg_data;
                pge_pkg::REG_BANDS_USED:  bands_used_reg  <= cfg_data[2:0];
                pge_pkg::REG_IMAGE_WIDTH: image_width_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] wid;
    logic [2:0]    nb;

    always_comb
    begin
        if (32'(image_width_reg) > 32'(MAX_WIDTH))
            wid = CW'(MAX_WIDTH);
        else if (image_width_reg < 13'd2)
            wid = CW'(2);
        else
            wid = CW'(image_width_reg);
        if (bands_used_reg == 3'd0)
            nb = 3'd1;
        else if (32'(bands_used_reg) > 32'(pge_pkg::MAX_BANDS))
            nb = 3'(pge_pkg::MAX_BANDS);
        else
            nb = bands_used_reg;
    end

    // position state
    pge_pkg::pge_state_t state_reg, state_next;

    logic                  acc;
    logic [PIX_W-1:0]      cur_pix;
    logic                  kept;
    logic [CW-1:0]         column_reg;
    logic                  row_first_reg;
    logic [INDEX_BITS-1:0] pixel_index_reg;
    logic [PIX_W-1:0]      left_pixel_reg;
    logic                  left_kept_reg;
    logic [CW-1:0]         col0, col1;
    logic                  first0, first1;
    logic [INDEX_BITS-1:0] idx0;
    logic                  leftk0;

    assign s_tready = (state_reg == pge_pkg::S_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign cur_pix  = s_tdata[PIX_W-1:0];
    assign kept     = s_tuser[0];

    always_comb
    begin
        col0   = s_tuser[1] ? '0 : column_reg;
        first0 = s_tuser[1] ? 1'b1 : row_first_reg;
        idx0   = s_tuser[1] ? '0 : pixel_index_reg;
        leftk0 = s_tuser[1] ? 1'b0 : left_kept_reg;
        // width shrunk mid-row starts a new row
        if (col0 >= wid)
        begin
            col0   = '0;
            first0 = 1'b0;
        end
        col1   = col0 + 1'b1;
        first1 = first0;
        if (col1 >= wid)
        begin
            col1   = '0;
            first1 = 1'b0;
        end
    end

    // per-pixel operands
    logic [PIX_W-1:0]      cur_reg;
    logic [PIX_W-1:0]      left_nbr_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [INDEX_BITS-1:0] wid_idx_reg;
    logic                  kept_reg;
    logic                  first_reg;
    logic                  left_en_reg;
    logic                  up_en_reg, up_en_next;
    logic                  edge_up_reg, edge_up_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg      <= '0;
            row_first_reg   <= 1'b1;
            pixel_index_reg <= '0;
            left_pixel_reg  <= '0;
            left_kept_reg   <= 1'b0;
        end
        else if (acc)
        begin
            column_reg      <= col1;
            row_first_reg   <= first1;
            pixel_index_reg <= idx0 + 1'b1;
            left_pixel_reg  <= cur_pix;
            left_kept_reg   <= kept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            cur_reg      <= cur_pix;
            left_nbr_reg <= left_pixel_reg;
            idx_reg      <= idx0;
            wid_idx_reg  <= INDEX_BITS'(wid);
            kept_reg     <= kept;
            first_reg    <= first0;
            left_en_reg  <= kept && (col0 != '0) && leftk0;
        end
    end

    // row store: read-first, single port
    logic [PIX_W:0] row_mem [MAX_WIDTH];
    logic [PIX_W:0] mem_rd_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            mem_rd_reg          <= row_mem[col0[AW-1:0]];
            row_mem[col0[AW-1:0]] <= {kept, cur_pix};
        end
    end

    // band lanes
    pge_pkg::pge_lane_ctl_t                          lane_ctl [pge_pkg::NUM_BANDS];
    logic [PIX_W-1:0]                                nbr_pix;
    logic [pge_pkg::NUM_BANDS-1:0][2*TERM_BITS-1:0]  lane_sq;
    logic [pge_pkg::NUM_BANDS-1:0]                   lane_valid;
    logic                                            lane_start;

    assign nbr_pix = edge_up_reg ? mem_rd_reg[PIX_W-1:0] : left_nbr_reg;

    for (genvar k = 0; k < pge_pkg::NUM_BANDS; k++)
    begin : g_lane
        assign lane_ctl[k].valid = lane_start;
        assign lane_ctl[k].used  = (3'(k) < nb);

        pge_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .TERM_BITS   (TERM_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (lane_ctl[k]),
            .cur      (cur_reg[k*SAMPLE_BITS +: SAMPLE_BITS]),
            .nbr      (nbr_pix[k*SAMPLE_BITS +: SAMPLE_BITS]),
            .weight   (weight_reg[k]),
            .sq       (lane_sq[k]),
            .sq_valid (lane_valid[k])
        );
    end

    pge_pkg::pge_merge_st_t          merge_st;
    logic [pge_pkg::DIST_BITS-1:0]   merge_dist;

    pge_merge #(
        .TERM_BITS (TERM_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lane_valid[0]),
        .sq        (lane_sq),
        .st        (merge_st),
        .root_dist (merge_dist)
    );

    // sequencer
    logic load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pge_pkg::S_IDLE;
            up_en_reg   <= 1'b0;
            edge_up_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            up_en_reg   <= up_en_next;
            edge_up_reg <= edge_up_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        up_en_next   = up_en_reg;
        edge_up_next = edge_up_reg;
        lane_start   = 1'b0;
        load         = 1'b0;
        unique case (state_reg)
            pge_pkg::S_IDLE:
            begin
                if (acc)
                    state_next = pge_pkg::S_READ;
            end
            pge_pkg::S_READ:
            begin
                up_en_next = kept_reg && !first_reg && mem_rd_reg[PIX_W];
                if (left_en_reg)
                begin
                    edge_up_next = 1'b0;
                    state_next   = pge_pkg::S_START;
                end
                else if (up_en_next)
                begin
                    edge_up_next = 1'b1;
                    state_next   = pge_pkg::S_START;
                end
                else
                    state_next = pge_pkg::S_IDLE;
            end
            pge_pkg::S_START:
            begin
                lane_start = 1'b1;
                state_next = pge_pkg::S_CALC;
            end
            pge_pkg::S_CALC:
            begin
                if (merge_st.done)
                    state_next = pge_pkg::S_LOAD;
            end
            pge_pkg::S_LOAD:
            begin
                if (!m_tvalid || m_tready)
                begin
                    load = 1'b1;
                    if (!edge_up_reg && up_en_reg)
                    begin
                        edge_up_next = 1'b1;
                        state_next   = pge_pkg::S_START;
                    end
                    else
                        state_next = pge_pkg::S_IDLE;
                end
            end
            default: state_next = pge_pkg::S_IDLE;
        endcase
    end

    // output register
    logic                          m_tvalid_reg;
    logic [INDEX_BITS-1:0]         from_reg;
    logic [INDEX_BITS-1:0]         to_reg;
    logic [pge_pkg::DIST_BITS-1:0] dist_reg;
    logic                          last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            from_reg <= edge_up_reg ? (idx_reg - wid_idx_reg) : (idx_reg - 1'b1);
            to_reg   <= idx_reg;
            dist_reg <= merge_dist;
            last_reg <= edge_up_reg || !up_en_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({dist_reg, to_reg, from_reg});
    assign m_tlast  = last_reg;

    `PGE_ASSERT_SAME(a_done_in_calc, merge_st.done, state_reg == pge_pkg::S_CALC, "root done outside calc")
    `PGE_ASSERT_SAME(a_load_free, load, !m_tvalid_reg || m_tready, "output overwritten")
    `PGE_ASSERT_SAME(a_idle_quiet, state_reg == pge_pkg::S_IDLE, !merge_st.busy, "root busy while idle")
    `PGE_ASSERT_NEXT(a_start_pipe, lane_start, !merge_st.done && state_reg == pge_pkg::S_CALC, "bad start")

endmodule

>>> hdl/pge_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pge_lane
// one band: weighted absolute difference, rounding, saturation and square
// ----------------------------------------------------------------------------
module pge_lane #(
    parameter int SAMPLE_BITS = pge_pkg::SAMPLE_BITS,
    parameter int TERM_BITS   = 22
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pge_pkg::pge_lane_ctl_t   ctl,
    input  logic [SAMPLE_BITS-1:0]   cur,
    input  logic [SAMPLE_BITS-1:0]   nbr,
    input  logic [15:0]              weight,
    output logic [2*TERM_BITS-1:0]   sq,
    output logic                     sq_valid
);

    localparam int PROD_W = SAMPLE_BITS + 16;
    localparam int FULL_W = SAMPLE_BITS + 6;

    logic [SAMPLE_BITS-1:0] diff;
    logic [PROD_W-1:0]      prod_reg;
    logic                   v1_reg;
    logic                   used1_reg;
    logic [PROD_W:0]        rnd;
    logic [FULL_W-1:0]      term_full;
    logic [TERM_BITS-1:0]   term;
    logic [2*TERM_BITS-1:0] sq_reg;
    logic                   v2_reg;

    assign diff = (cur > nbr) ? (cur - nbr) : (nbr - cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(diff) * PROD_W'(weight);
        used1_reg <= ctl.used;
        sq_reg    <= used1_reg ? (2*TERM_BITS)'(term) * (2*TERM_BITS)'(term)
                               : '0;
    end

    // round half up to 2 fractional bits, then clamp
    always_comb
    begin
        rnd       = {1'b0, prod_reg} + (PROD_W+1)'(pge_pkg::ROUND_ADD);
        term_full = rnd[PROD_W:11];
        if (term_full > FULL_W'(pge_pkg::TERM_MAX))
            term = TERM_BITS'(pge_pkg::TERM_MAX);
        else
            term = TERM_BITS'(term_full);
    end

    assign sq       = sq_reg;
    assign sq_valid = v2_reg;

endmodule

>>> hdl/pge_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pge_merge
// sums the lane squares and takes the integer square root, one bit per cycle
// ----------------------------------------------------------------------------
module pge_merge #(
    parameter int TERM_BITS = 22
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    input  logic [pge_pkg::NUM_BANDS-1:0][2*TERM_BITS-1:0] sq,
    output pge_pkg::pge_merge_st_t                        st,
    output logic [pge_pkg::DIST_BITS-1:0]                 root_dist
);

    localparam int SUM_W = 2*TERM_BITS + 2;
    localparam int RW    = TERM_BITS + 1;
    localparam int REM_W = RW + 3;
    localparam int CNT_W = $clog2(RW + 1);

    logic [SUM_W-1:0]                sum_reg, sum_next;
    logic [RW-1:0]                   root_reg, root_next;
    logic [REM_W-1:0]                rem_reg, rem_next;
    logic [CNT_W-1:0]                cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [pge_pkg::DIST_BITS-1:0]   dist_reg;
    logic [SUM_W-1:0]                total;
    logic [REM_W-1:0]                rem_sh;
    logic [REM_W-1:0]                trial;

    always_comb
    begin
        total = '0;
        for (int k = 0; k < pge_pkg::NUM_BANDS; k++)
            total = total + SUM_W'(sq[k]);
    end

    // one result bit per step
    always_comb
    begin
        rem_sh   = {rem_reg[RW:0], sum_reg[SUM_W-1 -: 2]};
        trial    = REM_W'({root_reg, 2'b01});
        sum_next = {sum_reg[SUM_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[RW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_reg[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (in_valid)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            sum_reg  <= total;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            sum_reg  <= sum_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            if (cnt_reg == CNT_W'(1))
            begin
                if (64'(root_next) > 64'(pge_pkg::DIST_MAX))
                    dist_reg <= pge_pkg::DIST_BITS'(pge_pkg::DIST_MAX);
                else
                    dist_reg <= pge_pkg::DIST_BITS'(root_next);
            end
        end
    end

    assign st.busy   = busy_reg;
    assign st.done   = done_reg;
    assign root_dist = dist_reg;

endmodule
